@@ hw/rtl/bwwa_pkg.sv @@
// Shared types and constants for the brightness-weighted window average block.
package bwwa_pkg;

   localparam int PIX_W      = 8;   // one color channel
   localparam int NUM_CH     = 3;   // red, green, blue
   localparam int CH_W       = 2;   // channel index
   localparam int SUM3_W     = 10;  // r + g + b
   localparam int WGT_W      = 10;  // pixel weight, at most 766
   localparam int SHIFT_W    = 4;
   localparam int QUOT_W     = 8;   // averages never exceed 255
   localparam int DIV_STEPS  = QUOT_W / 2;  // two quotient bits per step
   localparam int STEP_W     = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd7;

   typedef logic [PIX_W-1:0] pixel_type;

   // register index, byte address / 4
   typedef enum logic [0:0] {
      REG_WEIGHT_SHIFT = 1'b0
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_UPDATE,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic            accept;
      logic            load;
      logic            update;
      logic            div_init;
      logic            div_step;
      logic            div_last;
      logic            out_load;
      logic [CH_W-1:0] ch;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/bwwa_req_if.sv @@
// Pixel input channel: valid/ready plus one pixel and its column flag.
interface bwwa_req_if;
   import bwwa_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type in_red;
   pixel_type in_green;
   pixel_type in_blue;
   logic      column_start;

   modport source (output valid, in_red, in_green, in_blue, column_start, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, column_start, output ready);
endinterface

@@ hw/rtl/bwwa_rsp_if.sv @@
// Result channel: valid/ready plus one averaged pixel.
interface bwwa_rsp_if;
   import bwwa_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type out_red;
   pixel_type out_green;
   pixel_type out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

@@ hw/rtl/bwwa_csr.sv @@
// APB-style register port holding the weight shift.
module bwwa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bwwa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bwwa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bwwa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [bwwa_pkg::SHIFT_W-1:0]      weight_shift
);
   import bwwa_pkg::*;

   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   csr_reg_type        reg_idx;
   logic               wr_en;

   assign pready  = 1'b1;
   assign reg_idx = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      shift_in = shift_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WEIGHT_SHIFT: begin
               shift_in = pwdata[SHIFT_W-1:0];
            end
            default: begin
               shift_in = shift_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WEIGHT_SHIFT: begin
            prdata = {{(CSR_DATA_W-SHIFT_W){1'b0}}, shift_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else begin
         shift_ff <= shift_in;
      end
   end

   assign weight_shift = shift_ff;

endmodule

@@ hw/rtl/bwwa_ctrl.sv @@
// Sequencer: steps one pixel through load, sum update and, once the window is full, three divisions.
module bwwa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bwwa_pkg::dp_status_type status,
   output bwwa_pkg::dp_cmd_type    cmd
);
   import bwwa_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [CH_W-1:0]   ch_ff;
   logic [CH_W-1:0]   ch_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              last_ch;
   logic              last_step;

   assign last_ch   = (ch_ff == CH_W'(NUM_CH - 1));
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   // next state and sequence counters
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_UPDATE;
            ch_in    = '0;
         end
         ST_UPDATE: begin
            if (last_ch) begin
               ch_in    = '0;
               state_in = status.emit ? ST_DIV_INIT : ST_IDLE;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV_STEP;
            step_in  = '0;
         end
         ST_DIV_STEP: begin
            if (last_step) begin
               if (last_ch) begin
                  state_in = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_DIV_INIT;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      cmd.ch    = ch_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            cmd.div_last = last_step;
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ hw/rtl/bwwa_dp.sv @@
// Datapath: window ring memory, weighted sums, radix-4 divider, result register.
module bwwa_dp #(
   parameter int WINDOW = 96
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bwwa_pkg::dp_cmd_type         cmd,
   output bwwa_pkg::dp_status_type      status,
   input  logic [bwwa_pkg::SHIFT_W-1:0] weight_shift,
   input  bwwa_pkg::pixel_type          in_red,
   input  bwwa_pkg::pixel_type          in_green,
   input  bwwa_pkg::pixel_type          in_blue,
   input  logic                         column_start,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output bwwa_pkg::pixel_type          out_red,
   output bwwa_pkg::pixel_type          out_green,
   output bwwa_pkg::pixel_type          out_blue
);
   import bwwa_pkg::*;

   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int PTR_W   = $clog2(WINDOW);
   localparam int SUM_W   = PIX_W + WGT_W + CNT_W;
   localparam int TOT_W   = WGT_W + CNT_W + 1;
   localparam int PROD_W  = PIX_W + WGT_W;
   localparam int ENTRY_W = NUM_CH * PIX_W + WGT_W;

   // one restoring division step: shift in a dividend bit, subtract if it fits
   function automatic logic [TOT_W:0] div_bit(input logic [TOT_W-1:0] rem,
                                              input logic din,
                                              input logic [TOT_W-1:0] d);
      logic [TOT_W:0] trial;
      logic [TOT_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         return {diff[TOT_W-1:0], 1'b1};
      end
      return {trial[TOT_W-1:0], 1'b0};
   endfunction

   logic [ENTRY_W-1:0] ring_mem [WINDOW];

   pixel_type          pix_ff [NUM_CH];
   logic               start_ff;
   logic [WGT_W-1:0]   w_ff;
   logic [ENTRY_W-1:0] old_ff;
   logic [PTR_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [SUM_W-1:0]   sum_ff [NUM_CH];
   logic [TOT_W-1:0]   total_ff;
   logic               emit_ff;
   logic [TOT_W-1:0]   rem_ff;
   logic [TOT_W-1:0]   rem_in;
   logic [QUOT_W-1:0]  quo_ff;
   logic [QUOT_W-1:0]  quo_in;
   pixel_type          res_ff [NUM_CH];
   logic               rsp_valid_ff;
   pixel_type          out_red_ff;
   pixel_type          out_green_ff;
   pixel_type          out_blue_ff;

   logic [SUM3_W-1:0]  sum3;
   logic [WGT_W-1:0]   w_in;
   logic [PTR_W-1:0]   slot;
   logic               emit_now;
   logic [PTR_W-1:0]   ptr_in;
   logic [CNT_W-1:0]   fill_in;
   pixel_type          old_pix;
   logic [WGT_W-1:0]   old_w;
   logic [PROD_W-1:0]  sub_prod;
   logic [PROD_W-1:0]  add_prod;
   logic [SUM_W-1:0]   sum_sel;
   logic [SUM_W-1:0]   sum_upd;
   logic [TOT_W-1:0]   total_upd;
   logic [TOT_W:0]     step1;
   logic [TOT_W:0]     step2;

   // pixel weight
   assign sum3 = SUM3_W'(in_red) + SUM3_W'(in_green) + SUM3_W'(in_blue);
   assign w_in = WGT_W'(sum3 >> weight_shift) + WGT_W'(1);

   // column start resets the pointer and fill before this pixel
   assign slot     = start_ff ? '0 : ptr_ff;
   assign emit_now = !start_ff && (fill_ff == CNT_W'(WINDOW));
   assign ptr_in   = (slot == PTR_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
   assign fill_in  = emit_now ? fill_ff : (start_ff ? CNT_W'(1) : fill_ff + 1'b1);

   // sum update, one channel per cycle
   assign old_pix   = old_ff[WGT_W + cmd.ch * PIX_W +: PIX_W];
   assign old_w     = old_ff[WGT_W-1:0];
   assign sub_prod  = emit_ff ? old_pix * old_w : '0;
   assign add_prod  = pix_ff[cmd.ch] * w_ff;
   assign sum_sel   = sum_ff[cmd.ch];
   assign sum_upd   = sum_sel - SUM_W'(sub_prod) + SUM_W'(add_prod);
   assign total_upd = total_ff - (emit_ff ? TOT_W'(old_w) : '0) + TOT_W'(w_ff);

   // two quotient bits per cycle
   assign step1  = div_bit(rem_ff, quo_ff[QUOT_W-1], total_ff);
   assign step2  = div_bit(step1[TOT_W:1], quo_ff[QUOT_W-2], total_ff);
   assign rem_in = step2[TOT_W:1];
   assign quo_in = {quo_ff[QUOT_W-3:0], step1[0], step2[0]};

   // pixel capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff[0] <= in_red;
         pix_ff[1] <= in_green;
         pix_ff[2] <= in_blue;
         start_ff  <= column_start;
         w_ff      <= w_in;
      end
   end

   // ring memory, read-before-write at the same slot
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff         <= ring_mem[slot];
         ring_mem[slot] <= {pix_ff[2], pix_ff[1], pix_ff[0], w_ff};
      end
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         fill_ff  <= '0;
         total_ff <= TOT_W'(1);
         emit_ff  <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            ptr_ff  <= ptr_in;
            fill_ff <= fill_in;
            emit_ff <= emit_now;
            if (start_ff) begin
               total_ff <= TOT_W'(1);
               for (int i = 0; i < NUM_CH; i++) begin
                  sum_ff[i] <= '0;
               end
            end
         end
         if (cmd.update) begin
            sum_ff[cmd.ch] <= sum_upd;
            if (cmd.ch == '0) begin
               total_ff <= total_upd;
            end
         end
      end
   end

   // divider; quotient < 256 so the upper dividend bits start below the divisor
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= TOT_W'(sum_sel[SUM_W-1:QUOT_W]);
         quo_ff <= sum_sel[QUOT_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.div_last) begin
         res_ff[cmd.ch] <= quo_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_red_ff   <= res_ff[0];
         out_green_ff <= res_ff[1];
         out_blue_ff  <= res_ff[2];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign out_red         = out_red_ff;
   assign out_green       = out_green_ff;
   assign out_blue        = out_blue_ff;
   assign status.emit     = emit_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

@@ hw/rtl/brightness_weighted_window_average.sv @@
// Brightness-weighted sliding-window average over one image column (top level).
//
// Usage:
//   req_ch carries one RGB pixel per transfer, top to bottom down a column;
//   column_start = 1 marks the first pixel of a new column and restarts the
//   window. Each pixel is weighted by ((r+g+b) >> weight_shift) + 1.
//   The first WINDOW pixels of a column only prime the window; every later
//   pixel produces one transfer on rsp_ch with the weighted averages.
//   weight_shift sits at APB byte address 0 (reset value 7); write it only
//   while no pixel is in flight.
// Sequence:
//   Priming pixel: ring load and three sum updates, then the next pixel is
//   accepted. Emitting pixel: the same, then the shared radix-4 divider
//   runs per channel (load plus four steps), three times over, and the
//   result moves to the output register before the next pixel is accepted.
//   The next pixel does not wait for rsp_ch to take the previous result.
// Reset (synchronous): window empty, sums zero, weight total one, no result
//   pending; the ring memory is not cleared, it is always written first.
// Stall: a held result stays put; the next result waits in the sequencer,
//   with the input closed, until the output register frees up.
module brightness_weighted_window_average #(
   parameter int WINDOW = 96
) (
   input  logic                             clock,
   input  logic                             reset,
   bwwa_req_if.sink                         req_ch,
   bwwa_rsp_if.source                       rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bwwa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bwwa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bwwa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import bwwa_pkg::*;

   logic [SHIFT_W-1:0] weight_shift;
   dp_cmd_type         cmd;
   dp_status_type      status;

   // configuration registers
   bwwa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .weight_shift (weight_shift)
   );

   // sequencer: owns the input handshake and the channel/step counters
   bwwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ring memory, sums, divider and output register
   bwwa_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .weight_shift (weight_shift),
      .in_red       (req_ch.in_red),
      .in_green     (req_ch.in_green),
      .in_blue      (req_ch.in_blue),
      .column_start (req_ch.column_start),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .out_red      (rsp_ch.out_red),
      .out_green    (rsp_ch.out_green),
      .out_blue     (rsp_ch.out_blue)
   );

endmodule
